// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a holds at an edge, so b holds at the same edge
`define ASSERT_SAME(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// a holds at an edge, so b holds at the next edge
`define ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ===== design/gwdp_pkg.sv =====
`default_nettype none
package gwdp_pkg;
  localparam int MAX_ROWS_DEF = 32;
  localparam int MAX_COLS_DEF = 32;
  localparam int COORD_W = 5;
  localparam int CFG_W = 6;
  localparam int CFG_IDX_W = 2;
  localparam int DIST_W = 11;
  localparam int DIM_RESET = 32;

  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [1:0] action_t;

  localparam dist_t NO_PATH = '1;
  localparam dist_t DIST_SAT = NO_PATH - dist_t'(1);
  localparam dist_t DIST_CAP = dist_t'(1023);

  localparam action_t ACT_LOAD = 2'd0;
  localparam action_t ACT_DIST = 2'd1;
  localparam action_t ACT_NEXT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd2;
endpackage
`default_nettype wire

// ===== design/grid_wavefront_distance_planner.sv =====
`default_nettype none
// grid wavefront distance planner
// input channel: start is taken when busy is low; action selects an obstacle load
//   (no result), a distance query or a next-step query
// result channel: done pulses for one cycle with path_distance, next_row and
//   next_col; the receiver cannot stall it
// configuration: cfg_write with cfg_index and cfg_data, only while idle; a write to
//   rows, cols or mode, or any load, drops the cached distance field
// loads and queries outside the active grid finish without leaving idle
// a query on the cached goal reads the start cell's distance; a next step also
//   reads each neighbour, one field read each through the single read port
// a new goal first rebuilds the field: a clearing pass over MAX_ROWS*MAX_COLS
//   cells, then a queue-driven wavefront with one field read per neighbour of
//   each reachable cell, through the one read port of the field memory
// reset clears control and configuration state; memories are not cleared
module grid_wavefront_distance_planner
  import gwdp_pkg::*;
#(
  parameter int MAX_ROWS = gwdp_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = gwdp_pkg::MAX_COLS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [1:0]                      action,
  input  wire logic [gwdp_pkg::COORD_W-1:0]    cell_row,
  input  wire logic [gwdp_pkg::COORD_W-1:0]    cell_col,
  input  wire logic [gwdp_pkg::COORD_W-1:0]    goal_row,
  input  wire logic [gwdp_pkg::COORD_W-1:0]    goal_col,
  input  wire logic                            cell_blocked,
  output logic                                 done,
  output logic signed [gwdp_pkg::DIST_W-1:0]   path_distance,
  output logic [gwdp_pkg::COORD_W-1:0]         next_row,
  output logic [gwdp_pkg::COORD_W-1:0]         next_col,
  input  wire logic                            cfg_write,
  input  wire logic [gwdp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gwdp_pkg::CFG_W-1:0]      cfg_data
);
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW = $clog2(CELLS);
  localparam int PW = $clog2(CELLS + 1);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int NRW = $clog2(MAX_ROWS + 1);
  localparam int NCW = $clog2(MAX_COLS + 1);
  localparam int FW = DIST_W + 1;
  localparam int QW = DIST_W + RW + CW;
  localparam logic [NRW-1:0] ROWS_RST =
    NRW'((DIM_RESET > MAX_ROWS) ? MAX_ROWS : DIM_RESET);
  localparam logic [NCW-1:0] COLS_RST =
    NCW'((DIM_RESET > MAX_COLS) ? MAX_COLS : DIM_RESET);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CLEAR     = 4'd1;
  localparam logic [3:0] S_GOAL_RD   = 4'd2;
  localparam logic [3:0] S_GOAL_CHK  = 4'd3;
  localparam logic [3:0] S_DEQ       = 4'd4;
  localparam logic [3:0] S_DEQ_WAIT  = 4'd5;
  localparam logic [3:0] S_NB_ISSUE  = 4'd6;
  localparam logic [3:0] S_NB_CHK    = 4'd7;
  localparam logic [3:0] S_START_RD  = 4'd8;
  localparam logic [3:0] S_START_CHK = 4'd9;
  localparam logic [3:0] S_QN_ISSUE  = 4'd10;
  localparam logic [3:0] S_QN_CHK    = 4'd11;

  localparam logic [3:0] K_CENTER = 4'd4;
  localparam logic [3:0] K_END = 4'd9;

  logic [3:0] state;
  logic [NRW-1:0] num_rows;
  logic [NCW-1:0] num_cols;
  logic mode;
  logic field_valid;
  logic [COORD_W-1:0] cached_r, cached_c;
  action_t act;
  logic [COORD_W-1:0] sr, sc, gr, gc;
  logic [PW-1:0] clr_cnt;
  logic [PW-1:0] head, tail;
  logic [RW-1:0] base_r;
  logic [CW-1:0] base_c;
  dist_t cur_dist;
  logic [3:0] k;
  dist_t best;
  logic [RW-1:0] best_r;
  logic [CW-1:0] best_c;

  logic f_we;
  logic [AW-1:0] f_waddr, f_raddr;
  logic [FW-1:0] f_wdata, f_rdata;
  logic q_we;
  logic [QW-1:0] q_wdata, q_rdata;

  logic accept;
  logic load_ok, query_in_grid, cache_hit;
  logic [AW-1:0] load_addr, start_addr, goal_addr, nb_addr;
  logic [1:0] row_sel, col_sel;
  logic row_ok, col_ok, nb_ok;
  logic [RW-1:0] nb_r;
  logic [CW-1:0] nb_c;
  logic f_obs;
  dist_t f_dist, step_dist;
  logic fresh;

  function automatic logic [NRW-1:0] clamp_rows(input logic [CFG_W-1:0] v);
    int x;
    x = int'(v);
    if (x < 1) x = 1;
    if (x > MAX_ROWS) x = MAX_ROWS;
    return NRW'(x);
  endfunction

  function automatic logic [NCW-1:0] clamp_cols(input logic [CFG_W-1:0] v);
    int x;
    x = int'(v);
    if (x < 1) x = 1;
    if (x > MAX_COLS) x = MAX_COLS;
    return NCW'(x);
  endfunction

  function automatic dist_t to_out(input dist_t d);
    if (d == NO_PATH) return NO_PATH;
    if (d > DIST_CAP) return DIST_CAP;
    return d;
  endfunction

  assign busy = (state != S_IDLE);
  assign accept = start && !busy;

  assign load_ok = (int'(cell_row) < MAX_ROWS) && (int'(cell_col) < MAX_COLS);
  assign query_in_grid = (int'(cell_row) < int'(num_rows)) &&
                         (int'(cell_col) < int'(num_cols)) &&
                         (int'(goal_row) < int'(num_rows)) &&
                         (int'(goal_col) < int'(num_cols));
  assign cache_hit = field_valid && (cached_r == goal_row) && (cached_c == goal_col);

  assign load_addr = AW'(int'(cell_row) * MAX_COLS + int'(cell_col));
  assign start_addr = AW'(int'(sr) * MAX_COLS + int'(sc));
  assign goal_addr = AW'(int'(gr) * MAX_COLS + int'(gc));

  // neighbour k in row-major order around the base cell
  always_comb begin
    if (k < 4'd3) begin
      row_sel = 2'd0;
    end else if (k < 4'd6) begin
      row_sel = 2'd1;
    end else begin
      row_sel = 2'd2;
    end
    col_sel = 2'(k - 4'(3 * int'(row_sel)));
    case (row_sel)
      2'd0: begin
        row_ok = (base_r != '0);
        nb_r = base_r - RW'(1);
      end
      2'd2: begin
        row_ok = (int'(base_r) + 1 < int'(num_rows));
        nb_r = base_r + RW'(1);
      end
      default: begin
        row_ok = 1'b1;
        nb_r = base_r;
      end
    endcase
    case (col_sel)
      2'd0: begin
        col_ok = (base_c != '0);
        nb_c = base_c - CW'(1);
      end
      2'd2: begin
        col_ok = (int'(base_c) + 1 < int'(num_cols));
        nb_c = base_c + CW'(1);
      end
      default: begin
        col_ok = 1'b1;
        nb_c = base_c;
      end
    endcase
    nb_ok = (k < K_END) && (k != K_CENTER) && row_ok && col_ok &&
            (mode || row_sel == 2'd1 || col_sel == 2'd1);
    nb_addr = AW'(int'(nb_r) * MAX_COLS + int'(nb_c));
  end

  assign f_obs = f_rdata[FW-1];
  assign f_dist = f_rdata[DIST_W-1:0];
  assign step_dist = (cur_dist >= DIST_SAT) ? DIST_SAT : cur_dist + dist_t'(1);
  assign fresh = !f_obs && (f_dist == NO_PATH);

  always_comb begin
    f_we = 1'b0;
    f_waddr = nb_addr;
    f_wdata = {1'b0, step_dist};
    f_raddr = start_addr;
    q_we = 1'b0;
    q_wdata = {step_dist, nb_r, nb_c};
    unique case (state)
      S_IDLE: begin
        f_we = accept && (action == ACT_LOAD) && load_ok;
        f_waddr = load_addr;
        f_wdata = {cell_blocked, NO_PATH};
      end
      S_CLEAR: begin
        f_raddr = clr_cnt[AW-1:0];
        f_we = (clr_cnt != '0);
        f_waddr = AW'(clr_cnt - PW'(1));
        f_wdata = {f_obs, NO_PATH};
      end
      S_GOAL_RD: f_raddr = goal_addr;
      S_GOAL_CHK: begin
        f_we = !f_obs;
        f_waddr = goal_addr;
        f_wdata = {1'b0, dist_t'(0)};
        q_we = !f_obs;
        q_wdata = {dist_t'(0), RW'(gr), CW'(gc)};
      end
      S_NB_ISSUE, S_QN_ISSUE: f_raddr = nb_addr;
      S_NB_CHK: begin
        f_we = fresh;
        q_we = fresh;
      end
      default: ;
    endcase
  end

  gwdp_ram #(.WIDTH(FW), .DEPTH(CELLS)) u_field (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  gwdp_ram #(.WIDTH(QW), .DEPTH(CELLS)) u_queue (
    .clk(clk), .we(q_we), .waddr(tail[AW-1:0]), .wdata(q_wdata),
    .raddr(head[AW-1:0]), .rdata(q_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      num_rows <= ROWS_RST;
      num_cols <= COLS_RST;
      mode <= 1'b0;
      field_valid <= 1'b0;
      cached_r <= '0;
      cached_c <= '0;
      done <= 1'b0;
      clr_cnt <= '0;
      head <= '0;
      tail <= '0;
      k <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_ROWS: begin
            num_rows <= clamp_rows(cfg_data);
            field_valid <= 1'b0;
          end
          REG_COLS: begin
            num_cols <= clamp_cols(cfg_data);
            field_valid <= 1'b0;
          end
          REG_MODE: begin
            mode <= cfg_data[0];
            field_valid <= 1'b0;
          end
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            act <= action;
            sr <= cell_row;
            sc <= cell_col;
            gr <= goal_row;
            gc <= goal_col;
            if (action == ACT_LOAD) begin
              field_valid <= 1'b0;
            end else if (action == ACT_DIST || action == ACT_NEXT) begin
              if (!query_in_grid) begin
                done <= 1'b1;
                path_distance <= NO_PATH;
                next_row <= (action == ACT_NEXT) ? cell_row : '0;
                next_col <= (action == ACT_NEXT) ? cell_col : '0;
              end else if (cache_hit) begin
                state <= S_START_RD;
              end else begin
                clr_cnt <= '0;
                state <= S_CLEAR;
              end
            end
          end
        end
        S_CLEAR: begin
          if (clr_cnt == PW'(CELLS)) begin
            state <= S_GOAL_RD;
          end
          clr_cnt <= clr_cnt + PW'(1);
        end
        S_GOAL_RD: begin
          head <= '0;
          tail <= '0;
          state <= S_GOAL_CHK;
        end
        S_GOAL_CHK: begin
          if (!f_obs) begin
            tail <= tail + PW'(1);
          end
          state <= S_DEQ;
        end
        S_DEQ: begin
          if (head == tail) begin
            field_valid <= 1'b1;
            cached_r <= gr;
            cached_c <= gc;
            state <= S_START_RD;
          end else begin
            head <= head + PW'(1);
            state <= S_DEQ_WAIT;
          end
        end
        S_DEQ_WAIT: begin
          {cur_dist, base_r, base_c} <= q_rdata;
          k <= '0;
          state <= S_NB_ISSUE;
        end
        S_NB_ISSUE: begin
          if (k >= K_END) begin
            state <= S_DEQ;
          end else if (nb_ok) begin
            state <= S_NB_CHK;
          end else begin
            k <= k + 4'd1;
          end
        end
        S_NB_CHK: begin
          if (fresh) begin
            tail <= tail + PW'(1);
          end
          k <= k + 4'd1;
          state <= S_NB_ISSUE;
        end
        S_START_RD: state <= S_START_CHK;
        S_START_CHK: begin
          best <= f_dist;
          best_r <= RW'(sr);
          best_c <= CW'(sc);
          base_r <= RW'(sr);
          base_c <= CW'(sc);
          k <= '0;
          if (act == ACT_DIST) begin
            done <= 1'b1;
            path_distance <= to_out(f_dist);
            next_row <= '0;
            next_col <= '0;
            state <= S_IDLE;
          end else begin
            path_distance <= to_out(f_dist);
            state <= S_QN_ISSUE;
          end
        end
        S_QN_ISSUE: begin
          if (k >= K_END) begin
            done <= 1'b1;
            next_row <= COORD_W'(best_r);
            next_col <= COORD_W'(best_c);
            state <= S_IDLE;
          end else if (nb_ok) begin
            state <= S_QN_CHK;
          end else begin
            k <= k + 4'd1;
          end
        end
        S_QN_CHK: begin
          if (f_dist != NO_PATH && best != NO_PATH && f_dist < best) begin
            best <= f_dist;
            best_r <= nb_r;
            best_c <= nb_c;
          end
          k <= k + 4'd1;
          state <= S_QN_ISSUE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== design/gwdp_ram.sv =====
`default_nettype none
module gwdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/gwdp_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module gwdp_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                start,
  input wire logic                                busy,
  input wire logic [1:0]                          action,
  input wire logic                                done,
  input wire logic signed [gwdp_pkg::DIST_W-1:0]  path_distance
);
  import gwdp_pkg::*;

  // a result only shows once the block has returned to idle
  `ASSERT_SAME(a_done_idle, clk, rst, done, !busy)
  // loads never produce a result
  `ASSERT_NEXT(a_load_silent, clk, rst, start && !busy && action == ACT_LOAD, !done)
  // no transfer taken while idle means no result next cycle
  `ASSERT_NEXT(a_no_spurious, clk, rst, !busy && !start, !done)
  // the only negative distance is the no-path code
  `ASSERT_SAME(a_neg_is_none, clk, rst, done && path_distance[DIST_W-1],
    path_distance == NO_PATH)
endmodule

bind grid_wavefront_distance_planner gwdp_checker u_gwdp_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
  .done(done), .path_distance(path_distance)
);
`default_nettype wire
